// File: rtl/smpq_pkg.sv
// Shared constants and types for the stable min-priority queue.
package smpq_pkg;

  localparam int unsigned CAPACITY     = 64;
  localparam int unsigned PAYLOAD_BITS = 16;
  localparam int unsigned WEIGHT_BITS  = 32;
  localparam int unsigned CNT_W        = $clog2(CAPACITY + 1);

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_e;

  typedef struct packed {
    logic [PAYLOAD_BITS-1:0] payload;
    logic [WEIGHT_BITS-1:0]  weight;
  } entry_t;

  // broadcast to every cell
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t entry;
  } cell_op_t;

  typedef struct packed {
    logic [PAYLOAD_BITS-1:0] removed_payload;
    logic                    removed_valid;
    logic                    insert_dropped;
    logic                    is_empty;
    logic                    is_single;
    logic [CNT_W-1:0]        entry_count;
  } result_t;

endpackage

// File: rtl/smpq_in_if.sv
// Input channel: insert or remove-minimum requests.
interface smpq_in_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic [smpq_pkg::PAYLOAD_BITS-1:0]   payload;
  logic [smpq_pkg::WEIGHT_BITS-1:0]    weight;

  modport source (output valid, output kind, output payload, output weight, input ready);
  modport sink   (input valid, input kind, input payload, input weight, output ready);
endinterface

// File: rtl/smpq_out_if.sv
// Output channel: one result word per request.
interface smpq_out_if;
  logic                                valid;
  logic                                ready;
  logic [smpq_pkg::PAYLOAD_BITS-1:0]   removed_payload;
  logic                                removed_valid;
  logic                                insert_dropped;
  logic                                is_empty;
  logic                                is_single;
  logic [smpq_pkg::CNT_W-1:0]          entry_count;

  modport source (output valid, output removed_payload, output removed_valid,
                  output insert_dropped, output is_empty, output is_single,
                  output entry_count, input ready);
  modport sink   (input valid, input removed_payload, input removed_valid,
                  input insert_dropped, input is_empty, input is_single,
                  input entry_count, output ready);
endinterface

// File: rtl/stable_min_priority_queue_top.sv
// Top level of the stable min-priority queue built as a chain of sorted cells.
//
// in_i carries one request word: kind 0 inserts (payload, weight), kind 1
// removes the minimum-weight entry. Equal weights leave in arrival order.
// out_o returns exactly one result word per request: the removed payload
// and its valid flag, a drop flag for an insert into a full queue, and the
// occupancy after the request (empty, single, count).
// Every cell compares its weight with the broadcast request in parallel, so
// the whole chain updates on acceptance: one request per cycle is sustained
// while in_i.ready is high, and each result is registered in the result buffer.
// A two-word result buffer follows the core; in_i.ready drops only while
// both buffer words wait, so a stalled receiver holds the queue off after
// two requests and no result is lost.
// Reset empties the queue (count to zero) and the result buffer; the slot
// contents are not cleared and only an occupied slot's payload is returned.
module stable_min_priority_queue_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  smpq_in_if.sink     in_i,
  smpq_out_if.source  out_o
);

  localparam int unsigned N = smpq_pkg::CAPACITY;

  logic [smpq_pkg::CNT_W-1:0] count_q, count_d;
  logic                       accept, is_ins, full, do_ins, do_rem, buf_ready;
  smpq_pkg::cell_op_t         op;
  smpq_pkg::result_t          res;
  smpq_pkg::entry_t           entry   [N];
  smpq_pkg::entry_t           left_e  [N];
  smpq_pkg::entry_t           right_e [N];
  logic                       gt      [N];
  logic                       left_gt [N];

  assign in_i.ready = buf_ready;
  assign accept     = in_i.valid && in_i.ready;
  assign is_ins     = (in_i.kind == smpq_pkg::KIND_INSERT);
  assign full       = (count_q == smpq_pkg::CNT_W'(N));
  assign do_ins     = accept && is_ins && !full;
  assign do_rem     = accept && !is_ins && (count_q != '0);

  assign op.ins           = do_ins;
  assign op.rem           = do_rem;
  assign op.entry.payload = in_i.payload;
  assign op.entry.weight  = in_i.weight;

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_gt[i] = 1'b0;
      assign left_e[i]  = '0;
    end else begin : g_mid
      assign left_gt[i] = gt[i-1];
      assign left_e[i]  = entry[i-1];
    end
    if (i == N - 1) begin : g_last
      assign right_e[i] = '0;
    end else begin : g_next
      assign right_e[i] = entry[i+1];
    end

    smpq_cell u_cell (
      .clk_i      (clk_i),
      .op_i       (op),
      .occupied_i (smpq_pkg::CNT_W'(i) < count_q),
      .left_gt_i  (left_gt[i]),
      .left_i     (left_e[i]),
      .right_i    (right_e[i]),
      .gt_o       (gt[i]),
      .entry_o    (entry[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + smpq_pkg::CNT_W'(1);
    end else if (do_rem) begin
      count_d = count_q - smpq_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign res.removed_payload = do_rem ? entry[0].payload : '0;
  assign res.removed_valid   = do_rem;
  assign res.insert_dropped  = accept && is_ins && full;
  assign res.is_empty        = (count_d == '0);
  assign res.is_single       = (count_d == smpq_pkg::CNT_W'(1));
  assign res.entry_count     = count_d;

  smpq_res_buf u_res_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (res),
    .ready_o (buf_ready),
    .out_o   (out_o)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= smpq_pkg::CNT_W'(N))
    else $error("occupancy beyond capacity");

  a_front_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= smpq_pkg::CNT_W'(2)) |-> (entry[0].weight <= entry[1].weight))
    else $error("front slots out of weight order");

  a_drop_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_ins && (count_q != smpq_pkg::CNT_W'(N))) |=>
      (count_q == $past(count_q) + smpq_pkg::CNT_W'(1)))
    else $error("insert into non-full queue not stored");

  a_remove_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_ins && (count_q == '0)) |=> (count_q == '0))
    else $error("remove from empty queue changed occupancy");

endmodule

// File: rtl/smpq_cell.sv
// One slot of the sorted shift chain: keeps, loads new, or takes a neighbor.
module smpq_cell (
  input  logic               clk_i,
  input  smpq_pkg::cell_op_t op_i,
  input  logic               occupied_i,
  input  logic               left_gt_i,
  input  smpq_pkg::entry_t   left_i,
  input  smpq_pkg::entry_t   right_i,
  output logic               gt_o,
  output smpq_pkg::entry_t   entry_o
);

  smpq_pkg::entry_t entry_q, entry_d;

  // slot belongs after the new word: empty, or strictly heavier
  assign gt_o = !occupied_i || (entry_q.weight > op_i.entry.weight);

  always_comb begin
    entry_d = entry_q;
    if (op_i.ins) begin
      if (gt_o && !left_gt_i) begin
        entry_d = op_i.entry;
      end else if (gt_o) begin
        entry_d = left_i;
      end
    end else if (op_i.rem) begin
      entry_d = right_i;
    end
  end

  // entry storage (payload and weight), undefined until written
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// File: rtl/smpq_res_buf.sv
// Two-entry result buffer between the queue core and the output channel.
module smpq_res_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  smpq_pkg::result_t data_i,
  output logic              ready_o,
  smpq_out_if.source        out_o
);

  smpq_pkg::result_t head_q, head_d, tail_q, tail_d;
  logic [1:0]        cnt_q, cnt_d;
  logic              pop;

  assign pop     = out_o.valid && out_o.ready;
  assign ready_o = (cnt_q != 2'd2);

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    case ({push_i, pop})
      2'b10: begin
        if (cnt_q == 2'd0) begin
          head_d = data_i;
        end else begin
          tail_d = data_i;
        end
        cnt_d = cnt_q + 2'd1;
      end
      2'b01: begin
        head_d = tail_q;
        cnt_d  = cnt_q - 2'd1;
      end
      2'b11: begin
        if (cnt_q == 2'd1) begin
          head_d = data_i;
        end else begin
          head_d = tail_q;
          tail_d = data_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  assign out_o.valid           = (cnt_q != 2'd0);
  assign out_o.removed_payload = head_q.removed_payload;
  assign out_o.removed_valid   = head_q.removed_valid;
  assign out_o.insert_dropped  = head_q.insert_dropped;
  assign out_o.is_empty        = head_q.is_empty;
  assign out_o.is_single       = head_q.is_single;
  assign out_o.entry_count     = head_q.entry_count;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the stable min-priority queue: directed cases and random traffic with a mirror queue.
module testbench;

  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned RANDOM_ITEMS = 1600;
  localparam int unsigned CALM_FROM    = 1400;

  class queue_mirror;
    logic [smpq_pkg::PAYLOAD_BITS-1:0] slot_pay [smpq_pkg::CAPACITY];
    logic [smpq_pkg::WEIGHT_BITS-1:0]  slot_wt  [smpq_pkg::CAPACITY];
    int unsigned                       fill;
    smpq_pkg::result_t                 pending_results [$];
    int                                errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    function void note_request(smpq_pkg::kind_e k, logic [smpq_pkg::PAYLOAD_BITS-1:0] p,
                               logic [smpq_pkg::WEIGHT_BITS-1:0] w);
      smpq_pkg::result_t r;
      int unsigned       pos;
      r = '0;
      if (k == smpq_pkg::KIND_INSERT) begin
        if (fill >= smpq_pkg::CAPACITY) begin
          r.insert_dropped = 1'b1;
        end else begin
          pos = 0;
          while (pos < fill && slot_wt[pos] <= w) pos++;
          for (int unsigned i = fill; i > pos; i--) begin
            slot_pay[i] = slot_pay[i-1];
            slot_wt[i]  = slot_wt[i-1];
          end
          slot_pay[pos] = p;
          slot_wt[pos]  = w;
          fill++;
        end
      end else if (fill > 0) begin
        r.removed_payload = slot_pay[0];
        r.removed_valid   = 1'b1;
        for (int unsigned i = 1; i < fill; i++) begin
          slot_pay[i-1] = slot_pay[i];
          slot_wt[i-1]  = slot_wt[i];
        end
        fill--;
      end
      r.is_empty    = (fill == 0);
      r.is_single   = (fill == 1);
      r.entry_count = smpq_pkg::CNT_W'(fill);
      pending_results.push_back(r);
    endfunction

    task check_result(smpq_pkg::result_t got);
      smpq_pkg::result_t exp;
      if (pending_results.size() == 0) begin
        report("result word with no request pending");
        return;
      end
      exp = pending_results.pop_front();
      if (got.removed_payload !== exp.removed_payload)
        report($sformatf("removed_payload %h, expected %h",
                         got.removed_payload, exp.removed_payload));
      if (got.removed_valid !== exp.removed_valid)
        report($sformatf("removed_valid %b, expected %b",
                         got.removed_valid, exp.removed_valid));
      if (got.insert_dropped !== exp.insert_dropped)
        report($sformatf("insert_dropped %b, expected %b",
                         got.insert_dropped, exp.insert_dropped));
      if (got.is_empty !== exp.is_empty)
        report($sformatf("is_empty %b, expected %b", got.is_empty, exp.is_empty));
      if (got.is_single !== exp.is_single)
        report($sformatf("is_single %b, expected %b", got.is_single, exp.is_single));
      if (got.entry_count !== exp.entry_count)
        report($sformatf("entry_count %0d, expected %0d",
                         got.entry_count, exp.entry_count));
    endtask

    task flag_leftovers();
      if (pending_results.size() != 0)
        report($sformatf("%0d result words never arrived", pending_results.size()));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  bit   calm;
  bit   hold_req;

  queue_mirror mirror;

  smpq_in_if  in_ch ();
  smpq_out_if out_ch ();

  stable_min_priority_queue_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("testbench NOT OK");
    $finish;
  end

  function automatic logic [smpq_pkg::PAYLOAD_BITS-1:0] rand_pay();
    return smpq_pkg::PAYLOAD_BITS'($urandom());
  endfunction

  task automatic send_word(smpq_pkg::kind_e k, logic [smpq_pkg::PAYLOAD_BITS-1:0] p,
                           logic [smpq_pkg::WEIGHT_BITS-1:0] w);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.kind    <= k;
    in_ch.payload <= p;
    in_ch.weight  <= w;
    do @(posedge clk_i); while (!in_ch.ready);
    mirror.note_request(k, p, w);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (mirror.pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [smpq_pkg::WEIGHT_BITS-1:0] pick_weight();
    logic [smpq_pkg::WEIGHT_BITS-1:0] w;
    case ($urandom_range(0, 3))
      0, 1: w = $urandom_range(0, 7);
      2:    w = $urandom();
      default: begin
        case ($urandom_range(0, 3))
          0:       w = '0;
          1:       w = '1;
          2:       w = {1'b0, {(smpq_pkg::WEIGHT_BITS-1){1'b1}}};
          default: w = {1'b1, {(smpq_pkg::WEIGHT_BITS-1){1'b0}}};
        endcase
      end
    endcase
    return w;
  endfunction

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_side
    int                stall_left;
    smpq_pkg::result_t got;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        got.removed_payload = out_ch.removed_payload;
        got.removed_valid   = out_ch.removed_valid;
        got.insert_dropped  = out_ch.insert_dropped;
        got.is_empty        = out_ch.is_empty;
        got.is_single       = out_ch.is_single;
        got.entry_count     = out_ch.entry_count;
        mirror.check_result(got);
      end
      if (hold_req) begin
        stall_left = HOLD_CYCLES;
        hold_req   = 1'b0;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 8);
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : request_side
    int unsigned     random_sent;
    int unsigned     phase;
    int unsigned     phase_len;
    int unsigned     ins_pct;
    int unsigned     guard;
    smpq_pkg::kind_e k;
    mirror        = new();
    calm          = 1'b0;
    hold_req      = 1'b0;
    random_sent   = 0;
    phase         = 0;
    rst_ni        <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.kind    <= smpq_pkg::KIND_INSERT;
    in_ch.payload <= '0;
    in_ch.weight  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty remove, extremes, ties at front, middle and back
    send_word(smpq_pkg::KIND_REMOVE, '1, '1);
    send_word(smpq_pkg::KIND_INSERT, '0, '0);
    send_word(smpq_pkg::KIND_INSERT, '1, '1);
    send_word(smpq_pkg::KIND_INSERT, 16'h1111, 32'd5);
    send_word(smpq_pkg::KIND_INSERT, 16'h2222, 32'd5);
    send_word(smpq_pkg::KIND_INSERT, 16'h3333, 32'd5);
    send_word(smpq_pkg::KIND_INSERT, 16'h4444, '0);
    send_word(smpq_pkg::KIND_INSERT, 16'h5555, '1);
    send_word(smpq_pkg::KIND_INSERT, 16'h6666, 32'd4);
    repeat (8) send_word(smpq_pkg::KIND_REMOVE, rand_pay(), $urandom());
    send_word(smpq_pkg::KIND_INSERT, 16'hABCD, 32'h8000_0000);
    send_word(smpq_pkg::KIND_REMOVE, rand_pay(), $urandom());

    // fill past capacity, then drain past empty
    while (mirror.fill < smpq_pkg::CAPACITY)
      send_word(smpq_pkg::KIND_INSERT, rand_pay(), $urandom_range(0, 7));
    repeat (3) send_word(smpq_pkg::KIND_INSERT, rand_pay(), pick_weight());
    while (mirror.fill > 0) send_word(smpq_pkg::KIND_REMOVE, rand_pay(), $urandom());
    repeat (2) send_word(smpq_pkg::KIND_REMOVE, rand_pay(), $urandom());
    wait_drained();

    while (random_sent < RANDOM_ITEMS) begin
      calm      = (random_sent >= CALM_FROM) || ($urandom_range(0, 4) == 0);
      phase_len = $urandom_range(40, 120);
      case ($urandom_range(0, 2))
        0:       ins_pct = 50;
        1:       ins_pct = 85;
        default: ins_pct = 15;
      endcase
      if (phase == 2) begin
        ins_pct  = 85;
        hold_req = 1'b1;
      end
      repeat (phase_len) begin
        k = ($urandom_range(0, 99) < ins_pct) ? smpq_pkg::KIND_INSERT : smpq_pkg::KIND_REMOVE;
        send_word(k, rand_pay(), pick_weight());
        random_sent++;
      end
      if (phase == 1 || $urandom_range(0, 5) == 0) wait_drained();
      phase++;
    end

    in_ch.valid <= 1'b0;
    guard = 0;
    while (mirror.pending_results.size() != 0 && guard < 2000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (20) @(posedge clk_i);
    mirror.flag_leftovers();
    if (mirror.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/smpq_pkg.sv
rtl/smpq_in_if.sv
rtl/smpq_out_if.sv
rtl/smpq_cell.sv
rtl/smpq_res_buf.sv
rtl/stable_min_priority_queue_top.sv
tb/testbench.sv
